>>> sv/smcd_pkg.sv
// ----------------------------------------------------------------------------
// smcd_pkg
// Shared types and constants for the serial motor command decoder: byte type,
// keyword table in priority order and the keyword match result.
// ----------------------------------------------------------------------------
package smcd_pkg;

  typedef logic [7:0] byte_t;

  // command marker that restarts the buffer
  localparam byte_t CMD_MARK = 8'h40;

  // motor driver pin patterns
  localparam logic [4:0] DIR_NORTH = 5'h15;
  localparam logic [4:0] DIR_EAST  = 5'h16;
  localparam logic [4:0] DIR_SOUTH = 5'h0E;
  localparam logic [4:0] DIR_WEST  = 5'h0D;
  localparam logic [4:0] DIR_STOP  = 5'h00;

  // pwm duty range
  localparam byte_t SPEED_MAX = 8'd249;

  // keyword table, first entry has highest priority
  localparam int KW_COUNT   = 15;
  localparam int KW_MAX_LEN = 7;

  localparam byte_t KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"@", "N", "O", "R", "T", "E", 8'h00},
    '{"@", "E", "S", "T", "E", 8'h00, 8'h00},
    '{"@", "S", "U", "R", 8'h00, 8'h00, 8'h00},
    '{"@", "O", "E", "S", "T", "E", 8'h00},
    '{"@", "T", "U", "R", "B", "O", 8'h00},
    '{"@", "F", "A", "S", "T", "1", 8'h00},
    '{"@", "F", "A", "S", "T", "2", 8'h00},
    '{"@", "F", "A", "S", "T", "3", 8'h00},
    '{"@", "F", "A", "S", "T", "4", 8'h00},
    '{"@", "F", "A", "S", "T", "5", 8'h00},
    '{"@", "F", "A", "S", "T", "6", 8'h00},
    '{"@", "F", "A", "S", "T", "7", 8'h00},
    '{"@", "F", "A", "S", "T", "8", 8'h00},
    '{"@", "F", "A", "S", "T", "X", 8'h00},
    '{"@", "O", "R", "I", "G", "E", "N"}
  };

  localparam int KW_LEN [KW_COUNT] = '{6, 5, 4, 6, 6, 6, 6, 6, 6, 6, 6, 6, 6, 6, 7};

  localparam logic KW_IS_DIR [KW_COUNT] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
  };

  localparam byte_t KW_VALUE [KW_COUNT] = '{
    {3'b000, DIR_NORTH}, {3'b000, DIR_EAST}, {3'b000, DIR_SOUTH}, {3'b000, DIR_WEST},
    SPEED_MAX, 8'd0, 8'd25, 8'd50, 8'd75, 8'd100, 8'd125, 8'd150, 8'd175,
    SPEED_MAX, {3'b000, DIR_STOP}
  };

  // result of the keyword search
  typedef struct packed {
    logic  hit;
    logic  is_dir;
    byte_t value;
  } kw_hit_t;

endpackage

>>> sv/smcd_buffer.sv
// ----------------------------------------------------------------------------
// smcd_buffer
// Command byte buffer with write index. Presents the buffer contents as they
// stand after the incoming byte, and commits them on update.
// ----------------------------------------------------------------------------
module smcd_buffer #(
  parameter int BUFFER_LEN = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            upd,
  input  smcd_pkg::byte_t rx_byte,
  output smcd_pkg::byte_t buf_nxt [BUFFER_LEN]
);
  import smcd_pkg::*;

  localparam int CW = $clog2(BUFFER_LEN + 1);
  localparam int AW = $clog2(BUFFER_LEN);
  localparam logic [CW-1:0] FULL = CW'(BUFFER_LEN);

  byte_t         buf_r [BUFFER_LEN];
  logic [CW-1:0] idx_r;
  logic [CW-1:0] idx_nxt;
  logic [CW-1:0] idx_base;

  // marker restarts, full buffer clears and drops the byte
  always_comb begin
    idx_base = (rx_byte == CMD_MARK) ? '0 : idx_r;
    buf_nxt  = buf_r;
    if (idx_base == FULL) begin
      for (int j = 0; j < BUFFER_LEN; j++) begin
        buf_nxt[j] = '0;
      end
      idx_nxt = '0;
    end else begin
      buf_nxt[idx_base[AW-1:0]] = rx_byte;
      idx_nxt = idx_base + 1'b1;
    end
  end

  // buffer and index registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < BUFFER_LEN; j++) begin
        buf_r[j] <= '0;
      end
      idx_r <= '0;
    end else if (upd) begin
      buf_r <= buf_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

>>> sv/smcd_match.sv
// ----------------------------------------------------------------------------
// smcd_match
// Parallel keyword search over the buffer text (up to its first zero byte),
// returning the highest priority keyword found.
// ----------------------------------------------------------------------------
module smcd_match #(
  parameter int BUFFER_LEN = 10
) (
  input  smcd_pkg::byte_t   bytes [BUFFER_LEN],
  output smcd_pkg::kw_hit_t hit
);
  import smcd_pkg::*;

  logic [BUFFER_LEN-1:0] text_ok;
  logic [KW_COUNT-1:0]   kw_found;

  // a position is in the text while no zero byte came before or at it
  always_comb begin
    text_ok[0] = (bytes[0] != '0);
    for (int j = 1; j < BUFFER_LEN; j++) begin
      text_ok[j] = text_ok[j-1] && (bytes[j] != '0);
    end
  end

  // one comparator per keyword and start position
  always_comb begin
    logic pos_hit;
    for (int k = 0; k < KW_COUNT; k++) begin
      kw_found[k] = 1'b0;
      for (int p = 0; p < BUFFER_LEN; p++) begin
        pos_hit = 1'b1;
        for (int i = 0; i < KW_MAX_LEN; i++) begin
          if (i < KW_LEN[k]) begin
            if (p + i >= BUFFER_LEN) begin
              pos_hit = 1'b0;
            end else if (!text_ok[p+i] || (bytes[p+i] != KW_TEXT[k][i])) begin
              pos_hit = 1'b0;
            end
          end
        end
        kw_found[k] = kw_found[k] | pos_hit;
      end
    end
  end

  // priority pick, first keyword in the table wins
  always_comb begin
    hit = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (kw_found[k]) begin
        hit.hit    = 1'b1;
        hit.is_dir = KW_IS_DIR[k];
        hit.value  = KW_VALUE[k];
      end
    end
  end

endmodule

>>> sv/serial_motor_command_decoder_core.sv
// ----------------------------------------------------------------------------
// serial_motor_command_decoder_core
// Collects received serial bytes into a command buffer and decodes motor
// direction and speed keywords.
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries one received byte in in_rx_byte
//   result channel out_valid/out_ready carries the motor direction pattern
//   and speed duty as they stand after that byte; one result per byte
//   path: an accepted byte goes through the input register, then the buffer
//   update, keyword search and result register
//   throughput: one byte per cycle while out_ready holds, set by the
//   combinational keyword search over the whole buffer behind the input
//   register
//   reset: buffer cleared to zero bytes, index zero, direction stop, duty 0,
//   both channels empty
//   receiver stall: the result holds in its register, the input register
//   still takes one more byte, then in_ready falls until out_ready returns
// ----------------------------------------------------------------------------
module serial_motor_command_decoder_core #(
  parameter int BUFFER_LEN = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  smcd_pkg::byte_t in_rx_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [4:0]      out_motor_direction,
  output smcd_pkg::byte_t out_speed_duty
);
  import smcd_pkg::*;

  logic       in_valid_r;
  byte_t      in_byte_r;
  logic       out_valid_r;
  logic [4:0] dir_r;
  byte_t      speed_r;
  logic       advance;
  byte_t      buf_nxt [BUFFER_LEN];
  kw_hit_t    hit;

  // pipeline control
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // command buffer
  smcd_buffer #(
    .BUFFER_LEN(BUFFER_LEN)
  ) u_buffer (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (advance),
    .rx_byte(in_byte_r),
    .buf_nxt(buf_nxt)
  );

  // keyword search
  smcd_match #(
    .BUFFER_LEN(BUFFER_LEN)
  ) u_match (
    .bytes(buf_nxt),
    .hit  (hit)
  );

  // direction and speed state doubles as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      dir_r       <= DIR_STOP;
      speed_r     <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        if (hit.hit && hit.is_dir) begin
          dir_r <= hit.value[4:0];
        end
        if (hit.hit && !hit.is_dir) begin
          speed_r <= hit.value;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_motor_direction = dir_r;
  assign out_speed_duty      = speed_r;

  // checks
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_speed_duty <= SPEED_MAX)
    else $error("speed duty above pwm period");

  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_motor_direction == DIR_NORTH || out_motor_direction == DIR_EAST ||
    out_motor_direction == DIR_SOUTH || out_motor_direction == DIR_WEST ||
    out_motor_direction == DIR_STOP)
    else $error("illegal motor direction pattern");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("processed byte gave no result");

  a_no_change_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(dir_r) && $stable(speed_r))
    else $error("motor state changed without a byte");

endmodule
